// ===== design/lirs_pkg.sv =====
// Shared types and constants for the linear interpolation block resampler.
// No dependencies; every other design file imports this package.
package lirs_pkg;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int POS_W     = 12;
    localparam int IN_LEN_W  = 13;
    localparam int OUT_LEN_W = 12;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 32;

    // Signed weighted sum of two samples, weights up to 4095
    localparam int ACC_W = SAMPLE_W + OUT_LEN_W + 1;

    // Serial divider: dividend covers |acc| < 2^27, one quotient bit per cycle
    localparam int DIV_W   = 27;
    localparam int DCNT_W  = $clog2(DIV_W + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LEN = 2'd1;

    localparam logic [IN_LEN_W-1:0]  IN_LEN_RST  = 13'd950;
    localparam logic [OUT_LEN_W-1:0] OUT_LEN_RST = 12'd720;
    localparam logic [IN_LEN_W-1:0]  IN_LEN_MIN  = 13'd2;
    localparam logic [IN_LEN_W-1:0]  IN_LEN_MAX  = 13'd4096;

    // Divider request and response
    typedef struct packed {
        logic                    start;
        logic [DIV_W-1:0]        dividend;
        logic [OUT_LEN_W-1:0]    divisor;
    } lirs_div_req_t;

    typedef struct packed {
        logic                    done;
        logic [DIV_W-1:0]        quotient;
        logic [OUT_LEN_W-1:0]    remainder;
    } lirs_div_rsp_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_DIV_POS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_START_Y,
        ST_DIV_Y,
        ST_EMIT,
        ST_UPDATE
    } lirs_state_t;

endpackage

// ===== design/lirs_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on lirs_pkg for widths and the request/response structs.
module lirs_div import lirs_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  lirs_div_req_t req,
    output lirs_div_rsp_t rsp
);

    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [OUT_LEN_W-1:0] rem_reg, rem_next;
    logic [OUT_LEN_W-1:0] dvs_reg, dvs_next;
    logic [DCNT_W-1:0]    cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [OUT_LEN_W:0]   shifted;
    logic                 fits;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = DCNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = OUT_LEN_W'(shifted - {1'b0, dvs_reg});
            end else begin
                rem_next = shifted[OUT_LEN_W-1:0];
            end
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and result shift registers need no reset
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== design/linear_interp_block_resampler_top.sv =====
// Top level of the linear interpolation block resampler.
// Depends on lirs_pkg and the serial divider lirs_div.
//
// Takes signed 16-bit samples in blocks of in_block_len (clamped to 2..4096)
// and emits out_block_len outputs per block (clamped to 1..len-1). Output i
// sits at i*L/M = p + r/M and is (x[p]*(M-r) + x[p+1]*r)/M, truncated toward
// zero, sent when sample p+1 arrives (the last sample is repeated at the
// block end). One sample is processed at a time. Each sample that arrives
// while outputs of the block remain passes once through the shared 27-step
// bit-serial divider for the position p, r; a sample that yields an output
// uses it once more for the division of the weighted sum by M, and then
// waits while the result register stays full. A sample after the block's
// outputs are all sent skips the divider. The result register lets the next
// sample be accepted while a result waits.
module linear_interp_block_resampler_top import lirs_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Input samples
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,    // [15:0] sample_in
    // Resampled outputs
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,    // [15:0] sample_out, [27:16] out_position
    output logic                   m_tlast     // block_last
);

    lirs_state_t state_reg, state_next;

    logic [IN_LEN_W-1:0]        cfg_in_len_reg;
    logic [OUT_LEN_W-1:0]       cfg_out_len_reg;

    logic [IN_LEN_W-1:0]        l_reg;
    logic [OUT_LEN_W-1:0]       m_reg;
    logic [POS_W-1:0]           in_count_reg;
    logic [POS_W-1:0]           out_count_reg;
    logic signed [SAMPLE_W-1:0] cur_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic signed [SAMPLE_W-1:0] lo_reg;
    logic [OUT_LEN_W-1:0]       r_reg;
    logic                       fire_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       neg_reg;
    logic [SAMPLE_W-1:0]        y_reg;

    logic                       m_valid_reg;
    logic [SAMPLE_W-1:0]        m_sample_reg;
    logic [POS_W-1:0]           m_pos_reg;
    logic                       m_last_reg;

    logic [IN_LEN_W-1:0]        l_eff;
    logic [IN_LEN_W-1:0]        l_eff_m1;
    logic [OUT_LEN_W-1:0]       m_eff;
    logic [IN_LEN_W-1:0]        l_m1;
    logic [IN_LEN_W-1:0]        trig;
    logic                       past_end;
    logic [IN_LEN_W-1:0]        trig_eff;
    logic                       fire;
    logic [IN_LEN_W+POS_W-1:0]  pos;
    logic signed [ACC_W-1:0]    acc_abs;
    logic [SAMPLE_W-1:0]        q16;
    logic                       s_xfer;
    logic                       out_free;

    lirs_div_req_t div_req;
    lirs_div_rsp_t div_rsp;

    lirs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Clamp the configured lengths
    always_comb begin
        if (cfg_in_len_reg < IN_LEN_MIN) begin
            l_eff = IN_LEN_MIN;
        end else if (cfg_in_len_reg > IN_LEN_MAX) begin
            l_eff = IN_LEN_MAX;
        end else begin
            l_eff = cfg_in_len_reg;
        end
        l_eff_m1 = l_eff - 1'b1;
        if (cfg_out_len_reg == '0) begin
            m_eff = OUT_LEN_W'(1);
        end else if ({1'b0, cfg_out_len_reg} > l_eff_m1) begin
            m_eff = l_eff_m1[OUT_LEN_W-1:0];
        end else begin
            m_eff = cfg_out_len_reg;
        end
    end

    // Trigger sample of the pending output
    assign l_m1     = l_reg - 1'b1;
    assign trig     = {1'b0, div_rsp.quotient[POS_W-1:0]} + 1'b1;
    assign past_end = trig > l_m1;
    assign trig_eff = past_end ? l_m1 : trig;
    assign fire     = {1'b0, in_count_reg} == trig_eff;

    assign pos     = {{IN_LEN_W{1'b0}}, out_count_reg} * {{POS_W{1'b0}}, l_reg};
    assign acc_abs = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign q16     = div_rsp.quotient[SAMPLE_W-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Next state and divider requests
    always_comb begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(pos);
        div_req.divisor  = m_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = (out_count_reg < m_eff) ? ST_POS : ST_UPDATE;
                end
            end
            ST_POS: begin
                div_req.start = 1'b1;
                state_next    = ST_DIV_POS;
            end
            ST_DIV_POS: begin
                if (div_rsp.done) begin
                    state_next = fire ? ST_MUL_LO : ST_UPDATE;
                end
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_START_Y;
            ST_START_Y: begin
                div_req.start    = 1'b1;
                div_req.dividend = acc_abs[DIV_W-1:0];
                state_next       = ST_DIV_Y;
            end
            ST_DIV_Y: begin
                if (div_rsp.done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_in_len_reg  <= IN_LEN_RST;
            cfg_out_len_reg <= OUT_LEN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_IN_LEN:  cfg_in_len_reg  <= cfg_wdata;
                CFG_OUT_LEN: cfg_out_len_reg <= cfg_wdata[OUT_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Block counters and sample history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_count_reg  <= '0;
            out_count_reg <= '0;
            prev_reg      <= '0;
            fire_reg      <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        fire_reg <= 1'b0;
                    end
                end
                ST_DIV_POS: begin
                    if (div_rsp.done) begin
                        fire_reg <= fire;
                    end
                end
                ST_UPDATE: begin
                    prev_reg <= cur_reg;
                    if ({1'b0, in_count_reg} >= l_m1) begin
                        in_count_reg  <= '0;
                        out_count_reg <= '0;
                    end else begin
                        in_count_reg <= in_count_reg + 1'b1;
                        if (fire_reg) begin
                            out_count_reg <= out_count_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath: latch operands, weigh the two samples, sign-correct the quotient
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    cur_reg <= $signed(s_tdata[SAMPLE_W-1:0]);
                    l_reg   <= l_eff;
                    m_reg   <= m_eff;
                end
            end
            ST_DIV_POS: begin
                if (div_rsp.done) begin
                    r_reg  <= div_rsp.remainder;
                    lo_reg <= past_end ? cur_reg : prev_reg;
                end
            end
            ST_MUL_LO: begin
                acc_reg <= ACC_W'(lo_reg) *
                           ACC_W'($signed({1'b0, OUT_LEN_W'(m_reg - r_reg)}));
            end
            ST_MUL_HI: begin
                acc_reg <= acc_reg + ACC_W'(cur_reg) * ACC_W'($signed({1'b0, r_reg}));
            end
            ST_START_Y: begin
                neg_reg <= acc_reg[ACC_W-1];
            end
            ST_DIV_Y: begin
                if (div_rsp.done) begin
                    y_reg <= neg_reg ? SAMPLE_W'(-q16) : q16;
                end
            end
            default: ;
        endcase
    end

    // Result register: load on emit, drop after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT && out_free) begin
            m_sample_reg <= y_reg;
            m_pos_reg    <= out_count_reg;
            m_last_reg   <= (out_count_reg == m_reg - 1'b1);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_pos_reg, m_sample_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ===== design/lirs_checker.sv =====
// Port-level checker for the resampler top level, bound to every instance.
// Depends on lirs_pkg for port widths.
module lirs_checker import lirs_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata,
    input logic                   m_tlast
);

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One sample at a time: an input transfer closes the input side
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a sample is in work");

    // A new result only appears while a sample is still in work
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !s_tready)
        else $error("result appeared with no sample in work");

    // A stalled result holds
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind linear_interp_block_resampler_top lirs_checker u_lirs_checker (.*);
